// File: hdl/lmwls_pkg.sv
// ----------------------------------------------------------------------------
// lmwls_pkg
// Shared types and field widths of the weighted-level LED matrix scanner.
// ----------------------------------------------------------------------------
package lmwls_pkg;

  // field widths of the stream items and the limit register
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned LED_W       = 6;
  localparam int unsigned INTEN_W     = 8;
  localparam int unsigned BANK_NUM_W  = 3;
  localparam int unsigned SEG_DRIVE_W = 12;
  localparam int unsigned LIMIT_W     = 8;

  // padded stream data widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  // number of distinct led index codes
  localparam int unsigned LED_CODES = 2 ** LED_W;

  // limit register value after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd4;

  // item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_ACCESS = 2'b10
  } state_e;

endpackage

// File: hdl/lmwls_ram.sv
// ----------------------------------------------------------------------------
// lmwls_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lmwls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data while not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/led_matrix_weighted_level_scanner_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_weighted_level_scanner_unit
// Multiplexed LED matrix scanner with binary-weighted brightness levels.
// ----------------------------------------------------------------------------
// Tick and in-range set items take a mask RAM read, then the output load or
// the bank word write-back; a tick result is loaded into the output register
// once it is free, and a full output register holds the tick and the input.
// Clear-all, out-of-range sets and unused codes need no access state, no result.
// Reset clears the per-bank valid bits at once (masks read as zero), no
// clearing pass; the limit register resets to 4, the bank counter to BANKS.
module led_matrix_weighted_level_scanner_unit #(
  parameter int unsigned BANKS    = 5,
  parameter int unsigned SEGMENTS = 12,
  parameter int unsigned LEVELS   = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [5:0] led_num, [13:6] intensity_value, [15:14] zero
  input  logic [lmwls_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] func
  input  logic [lmwls_pkg::FUNC_W-1:0]       s_axis_tuser,
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] bank_sel, [14:3] segment_drive, [15] zero
  output logic [lmwls_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // limit register write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lmwls_pkg::LIMIT_W-1:0]      cfg_data_i
);

  localparam int unsigned BANK_W  = $clog2(BANKS);
  localparam int unsigned BPOS_W  = $clog2(BANKS + 1);
  localparam int unsigned SEG_IW  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned SWEEP_W = LEVELS;
  localparam int unsigned WORD_W  = SEGMENTS * LEVELS;
  localparam int unsigned LED_MAX = BANKS * SEGMENTS;
  localparam int unsigned SEG_PAD_W =
    (SEGMENTS > lmwls_pkg::SEG_DRIVE_W) ? SEGMENTS : lmwls_pkg::SEG_DRIVE_W;

  // input field split
  logic [lmwls_pkg::LED_W-1:0]   in_led;
  logic [lmwls_pkg::INTEN_W-1:0] in_inten;
  lmwls_pkg::func_e              in_func;
  logic                          in_accept;

  assign in_led    = s_axis_tdata[lmwls_pkg::LED_W-1:0];
  assign in_inten  = s_axis_tdata[lmwls_pkg::LED_W +: lmwls_pkg::INTEN_W];
  assign in_func   = lmwls_pkg::func_e'(s_axis_tuser);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // led index to segment and zigzag bank, worked out at elaboration
  logic [SEG_IW-1:0] seg_lut  [lmwls_pkg::LED_CODES];
  logic [BANK_W-1:0] bank_lut [lmwls_pkg::LED_CODES];

  for (genvar g = 0; g < lmwls_pkg::LED_CODES; g++) begin : g_lut
    localparam int unsigned SEG = g / BANKS;
    localparam int unsigned REM = g % BANKS;
    localparam int unsigned BNK = (SEG % 2 == 1) ? ((REM == 0) ? 0 : BANKS - REM) : REM;
    assign seg_lut[g]  = SEG_IW'(SEG);
    assign bank_lut[g] = BANK_W'(BNK);
  end

  // control state
  lmwls_pkg::state_e            state_q, state_d;
  logic [lmwls_pkg::LIMIT_W-1:0] limit_q;
  logic [BPOS_W-1:0]            bank_pos_q, bank_pos_d;
  logic [LVL_W-1:0]             level_q, level_d;
  logic [SWEEP_W-1:0]           sweeps_q, sweeps_d;
  logic [BANKS-1:0]             valid_q, valid_d;
  logic                         out_valid_q, out_valid_d;

  // access stage payload
  logic                op_tick_q, op_tick_d;
  logic [BANK_W-1:0]   bank_q, bank_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [SEGMENTS-1:0] seg_oh_q, seg_oh_d;
  logic [LEVELS-1:0]   lit_q, lit_d;

  // output register
  logic [BANK_W-1:0]   out_bank_q, out_bank_d;
  logic [SEGMENTS-1:0] out_mask_q, out_mask_d;

  // ram ports
  logic              ram_we, ram_re;
  logic [BANK_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  lmwls_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BANKS)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bank_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // decode of a new item
  logic              led_ok;
  logic [BPOS_W-1:0] bpos_norm;
  logic [BANK_W-1:0] tick_bank;

  assign led_ok    = 32'(in_led) < LED_MAX;
  assign bpos_norm = (bank_pos_q == '0 || 32'(bank_pos_q) > BANKS) ? BPOS_W'(BANKS)
                                                                    : bank_pos_q;
  assign tick_bank = BANK_W'(bpos_norm - BPOS_W'(1));

  // stored word of the bank in flight, zero when not written since reset or clear-all
  logic [WORD_W-1:0]   word_cur;
  logic [SEGMENTS-1:0] tick_mask;

  assign word_cur  = valid_q[bank_q] ? ram_rdata : '0;
  assign tick_mask = word_cur[32'(lvl_q) * SEGMENTS +: SEGMENTS];

  // segment bit rewritten in every level slice
  always_comb begin
    ram_wdata = word_cur;
    for (int i = 0; i < LEVELS; i++) begin
      if (lit_q[i]) begin
        ram_wdata[i*SEGMENTS +: SEGMENTS] = word_cur[i*SEGMENTS +: SEGMENTS] | seg_oh_q;
      end else begin
        ram_wdata[i*SEGMENTS +: SEGMENTS] = word_cur[i*SEGMENTS +: SEGMENTS] & ~seg_oh_q;
      end
    end
  end

  // sequencer, counters and read issue
  always_comb begin
    state_d     = state_q;
    bank_pos_d  = bank_pos_q;
    level_d     = level_q;
    sweeps_d    = sweeps_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    op_tick_d   = op_tick_q;
    bank_d      = bank_q;
    lvl_d       = lvl_q;
    seg_oh_d    = seg_oh_q;
    lit_d       = lit_q;
    out_bank_d  = out_bank_q;
    out_mask_d  = out_mask_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = tick_bank;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      lmwls_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (in_func)
            lmwls_pkg::FUNC_TICK: begin
              ram_re    = 1'b1;
              ram_raddr = tick_bank;
              op_tick_d = 1'b1;
              bank_d    = tick_bank;
              lvl_d     = level_q;
              state_d   = lmwls_pkg::ST_ACCESS;
              // bank counter and level schedule
              if (tick_bank == '0) begin
                bank_pos_d = BPOS_W'(BANKS);
                sweeps_d   = sweeps_q - SWEEP_W'(1);
                if (sweeps_q == SWEEP_W'(1)) begin
                  if (level_q == LVL_W'(LEVELS - 1)) begin
                    level_d  = '0;
                    sweeps_d = SWEEP_W'(1);
                  end else begin
                    level_d  = level_q + LVL_W'(1);
                    sweeps_d = SWEEP_W'(1) << (level_q + LVL_W'(1));
                  end
                end
              end else begin
                bank_pos_d = BPOS_W'(tick_bank);
              end
            end
            lmwls_pkg::FUNC_SET: begin
              if (led_ok) begin
                ram_re    = 1'b1;
                ram_raddr = bank_lut[in_led];
                op_tick_d = 1'b0;
                bank_d    = bank_lut[in_led];
                seg_oh_d  = SEGMENTS'(1) << seg_lut[in_led];
                for (int i = 0; i < LEVELS; i++) begin
                  lit_d[i] = (32'(in_inten) > i) && (i < 32'(limit_q));
                end
                state_d   = lmwls_pkg::ST_ACCESS;
              end
            end
            lmwls_pkg::FUNC_CLEAR: begin
              valid_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      lmwls_pkg::ST_ACCESS: begin
        if (op_tick_q) begin
          // wait for the output register to be free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_d = 1'b1;
            out_bank_d  = bank_q;
            out_mask_d  = tick_mask;
            state_d     = lmwls_pkg::ST_IDLE;
          end
        end else begin
          ram_we           = 1'b1;
          valid_d[bank_q]  = 1'b1;
          state_d          = lmwls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lmwls_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmwls_pkg::ST_IDLE;
      limit_q     <= lmwls_pkg::LIMIT_RESET;
      bank_pos_q  <= BPOS_W'(BANKS);
      level_q     <= '0;
      sweeps_q    <= SWEEP_W'(1);
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_pos_q  <= bank_pos_d;
      level_q     <= level_d;
      sweeps_q    <= sweeps_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_tick_q  <= op_tick_d;
    bank_q     <= bank_d;
    lvl_q      <= lvl_d;
    seg_oh_q   <= seg_oh_d;
    lit_q      <= lit_d;
    out_bank_q <= out_bank_d;
    out_mask_q <= out_mask_d;
  end

  // output packing
  logic [SEG_PAD_W-1:0] out_mask_pad;

  assign out_mask_pad  = SEG_PAD_W'(out_mask_q);
  assign s_axis_tready = (state_q == lmwls_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_mask_pad[lmwls_pkg::SEG_DRIVE_W-1:0],
                          lmwls_pkg::BANK_NUM_W'(out_bank_q)};

  // checks
  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("mask ram read and write in the same cycle");

  a_clear_all : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_func == lmwls_pkg::FUNC_CLEAR) |=> (valid_q == '0))
    else $error("clear-all left a bank valid");

  a_bank_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(out_bank_q) < BANKS))
    else $error("emitted bank out of range");

  a_schedule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(level_q) < LEVELS) && (sweeps_q != '0))
    else $error("level schedule out of range");

endmodule
